// ----- rtl/rrwa_pkg.sv -----
// Shared types, widths and the quarter-wave sine table of the ripple warp address block.
`default_nettype none
package rrwa_pkg;

  localparam int CoordW  = 10;            // pixel coordinate
  localparam int SizeW   = 11;            // image size register
  localparam int RingW   = 9;             // ring index
  localparam int StepW   = 13;            // phase step
  localparam int AmpW    = 16;            // gains
  localparam int PhaseW  = 10;            // sine table address
  localparam int RadW    = 22;            // cx^2 + cy^2 and halfw^2 + halfh^2
  localparam int RadSclW = 40;            // radius scaled by rings^2
  localparam int AccW    = 42;            // d^2 * S accumulator
  localparam int DsW     = 32;            // d * S accumulator
  localparam int OffW    = 17;            // offset after the Q15 shift
  localparam int QtrN    = 257;           // quarter wave plus end point

  // APB register indexes
  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegXAmp   = 3'd2;
  localparam logic [2:0] RegYAmp   = 3'd3;
  localparam logic [2:0] RegStep   = 3'd4;

  typedef logic [14:0] qsin_t [0:QtrN-1];

  // Ring search payload
  typedef struct packed {
    logic [CoordW-1:0]  px;
    logic [CoordW-1:0]  py;
    logic [RadSclW-1:0] rs;
    logic [AccW-1:0]    dsqs;
    logic [DsW-1:0]     ds;
    logic [RingW-1:0]   d;
  } srch_t;

  // Offset payload
  typedef struct packed {
    logic [CoordW-1:0]      px;
    logic [CoordW-1:0]      py;
    logic signed [OffW-1:0] offx;
    logic signed [OffW-1:0] offy;
  } offs_t;

  function automatic qsin_t qsin_build();
    qsin_t q;
    real   a;
    for (int j = 0; j < QtrN; j++) begin
      a    = $sin(j * 3.14159265358979323846 / 512.0) * 32767.0;
      q[j] = 15'($rtoi(a));
    end
    q[0]      = 15'd0;
    q[QtrN-1] = 15'd32767;
    return q;
  endfunction

  localparam qsin_t QSIN = qsin_build();

  // Full-wave Q15 sine from the quarter table
  function automatic logic signed [AmpW-1:0] sine_read(logic [PhaseW-1:0] j);
    logic [8:0]        k;
    logic [8:0]        idx;
    logic [AmpW-1:0]   v;
    k   = j[8:0];
    idx = (k <= 9'd256) ? k : 9'(10'd512 - {1'b0, k});
    v   = {1'b0, QSIN[idx]};
    return j[9] ? -$signed(v) : $signed(v);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/radial_ripple_warp_address.sv -----
// Top level of the radial ripple warp address generator.
// Maps each destination pixel to a clamped source pixel for a radial ripple warp. One pixel
// per clock is accepted unless the output stalls. Three stages form the centred radius, nine
// stages resolve the ring index one bit each with add-and-compare against the scaled radius,
// three stages compute phase, sine/cosine lookup and gain, and a final stage adds and clamps.
// Stalls only back up until bubbles are squeezed out. Registers (APB, byte address 4*i):
// image_width, image_height, x_amplitude, y_amplitude, phase_step; write them only while idle.
`default_nettype none
module radial_ripple_warp_address #(
  parameter int MAX_DIM = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // source_x[9:0], source_y[19:10], zero pad
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = rrwa_pkg::CoordW;
  localparam int NS = rrwa_pkg::RingW;
  localparam int MW = 13;

  // configuration
  logic [rrwa_pkg::SizeW-1:0]        image_width, image_height;
  logic signed [rrwa_pkg::AmpW-1:0]  x_amplitude, y_amplitude;
  logic [rrwa_pkg::StepW-1:0]        phase_step;
  logic [rrwa_pkg::RadW-1:0]         s_cfg;
  logic [CW-1:0]                     halfw, halfh;
  logic [MW-1:0]                     maxx, maxy;
  logic                              wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign halfw  = image_width[rrwa_pkg::SizeW-1:1];
  assign halfh  = image_height[rrwa_pkg::SizeW-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rrwa_pkg::SizeW'(320);
      image_height <= rrwa_pkg::SizeW'(240);
      x_amplitude  <= '0;
      y_amplitude  <= '0;
      phase_step   <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (paddr[4:2])
        rrwa_pkg::RegWidth:  image_width  <= pwdata[rrwa_pkg::SizeW-1:0];
        rrwa_pkg::RegHeight: image_height <= pwdata[rrwa_pkg::SizeW-1:0];
        rrwa_pkg::RegXAmp:   x_amplitude  <= pwdata[rrwa_pkg::AmpW-1:0];
        rrwa_pkg::RegYAmp:   y_amplitude  <= pwdata[rrwa_pkg::AmpW-1:0];
        rrwa_pkg::RegStep:   phase_step   <= pwdata[rrwa_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      rrwa_pkg::RegWidth:  prdata = 32'(image_width);
      rrwa_pkg::RegHeight: prdata = 32'(image_height);
      rrwa_pkg::RegXAmp:   prdata = 32'($unsigned(x_amplitude));
      rrwa_pkg::RegYAmp:   prdata = 32'($unsigned(y_amplitude));
      rrwa_pkg::RegStep:   prdata = 32'(phase_step);
      default:             prdata = '0;
    endcase
  end

  // derived constants, settled well before the idle-only config window closes
  always_ff @(posedge clk) begin
    s_cfg <= rrwa_pkg::RadW'(halfw) * rrwa_pkg::RadW'(halfw)
           + rrwa_pkg::RadW'(halfh) * rrwa_pkg::RadW'(halfh);
    if (image_width == '0)                    maxx <= '0;
    else if (MW'(image_width) > MW'(MAX_DIM)) maxx <= MW'(MAX_DIM - 1);
    else                                      maxx <= MW'(image_width) - MW'(1);
    if (image_height == '0)                    maxy <= '0;
    else if (MW'(image_height) > MW'(MAX_DIM)) maxy <= MW'(MAX_DIM - 1);
    else                                       maxy <= MW'(image_height) - MW'(1);
  end

  // front: centre, square, sum
  logic                       va, vb, vc;
  logic                       lda, ldb, ldc;
  logic [CW-1:0]              pxa, pya, pxb, pyb;
  logic signed [CW:0]         cxa, cya;
  logic [2*CW-1:0]            cxsq, cysq;
  rrwa_pkg::srch_t            sc;

  logic [NS:0]                sv;
  logic [NS:0]                srdy;
  rrwa_pkg::srch_t            sd [0:NS];

  assign sv[0] = vc;
  assign sd[0] = sc;

  assign ldc           = !vc || srdy[0];
  assign ldb           = !vb || ldc;
  assign lda           = !va || ldb;
  assign s_axis_tready = lda;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (lda) va <= s_axis_tvalid;
      if (ldb) vb <= va;
      if (ldc) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (lda && s_axis_tvalid) begin
      pxa <= s_axis_tdata[CW-1:0];
      pya <= s_axis_tdata[2*CW-1:CW];
      cxa <= $signed({1'b0, s_axis_tdata[CW-1:0]}) - $signed({1'b0, halfw});
      cya <= $signed({1'b0, s_axis_tdata[2*CW-1:CW]}) - $signed({1'b0, halfh});
    end
    if (ldb && va) begin
      pxb  <= pxa;
      pyb  <= pya;
      cxsq <= (2*CW)'($unsigned((2*CW+2)'(cxa) * (2*CW+2)'(cxa)));
      cysq <= (2*CW)'($unsigned((2*CW+2)'(cya) * (2*CW+2)'(cya)));
    end
    if (ldc && vb) begin
      sc.px   <= pxb;
      sc.py   <= pyb;
      sc.rs   <= rrwa_pkg::RadSclW'({rrwa_pkg::RadW'(cxsq) + rrwa_pkg::RadW'(cysq), 18'd0});
      sc.dsqs <= '0;
      sc.ds   <= '0;
      sc.d    <= '0;
    end
  end

  // ring search, most significant bit first
  for (genvar g = 0; g < NS; g++) begin : g_srch
    rrwa_search #(.K(NS - 1 - g)) u_srch (
      .clk       (clk),
      .rst       (rst),
      .s_cfg     (s_cfg),
      .in_valid  (sv[g]),
      .in_ready  (srdy[g]),
      .in_data   (sd[g]),
      .out_valid (sv[g+1]),
      .out_ready (srdy[g+1]),
      .out_data  (sd[g+1])
    );
  end

  logic            ov;
  logic            ldo;
  rrwa_pkg::offs_t od;

  rrwa_offset u_offs (
    .clk         (clk),
    .rst         (rst),
    .phase_step  (phase_step),
    .x_amplitude (x_amplitude),
    .y_amplitude (y_amplitude),
    .in_valid    (sv[NS]),
    .in_ready    (srdy[NS]),
    .in_data     (sd[NS]),
    .out_valid   (ov),
    .out_ready   (ldo),
    .out_data    (od)
  );

  // add and clamp into the output register
  localparam int SW = rrwa_pkg::OffW + 1;
  logic signed [SW-1:0] sumx, sumy;
  logic [CW-1:0]        outx, outy;

  assign ldo  = !m_axis_tvalid || m_axis_tready;
  assign sumx = $signed({{(SW-CW){1'b0}}, od.px}) + SW'(od.offx);
  assign sumy = $signed({{(SW-CW){1'b0}}, od.py}) + SW'(od.offy);

  always_comb begin
    if (sumx < 0)                          outx = '0;
    else if (sumx > $signed(SW'(maxx)))    outx = maxx[CW-1:0];
    else                                   outx = sumx[CW-1:0];
    if (sumy < 0)                          outy = '0;
    else if (sumy > $signed(SW'(maxy)))    outy = maxy[CW-1:0];
    else                                   outy = sumy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ldo) begin
      m_axis_tvalid <= ov;
    end
  end

  always_ff @(posedge clk) begin
    if (ldo && ov) begin
      m_axis_tdata <= {4'd0, outy, outx};
    end
  end

  // checks
  a_in_to_stage: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> va)
    else $error("accepted beat did not enter the pipeline");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ov && !ldo |=> ov && $stable(od))
    else $error("offset stage changed while output stalled");

  a_clamp_x: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> {3'd0, m_axis_tdata[CW-1:0]} <= maxx)
    else $error("source_x beyond clamp limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !va)
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ----- rtl/rrwa_search.sv -----
// One bit of the ring index search: a stage that tests d|bit against the scaled radius.
`default_nettype none
module rrwa_search #(
  parameter int K = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rrwa_pkg::RadW-1:0]     s_cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rrwa_pkg::srch_t               in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rrwa_pkg::srch_t                    out_data
);

  logic [rrwa_pkg::AccW-1:0] cand;
  logic                      take;
  rrwa_pkg::srch_t           nxt;

  // (d + 2^K)^2 * S = d^2*S + d*S*2^(K+1) + S*2^(2K)
  always_comb begin
    cand = in_data.dsqs
         + (rrwa_pkg::AccW'(in_data.ds) << (K + 1))
         + (rrwa_pkg::AccW'(s_cfg) << (2 * K));
    take = cand <= rrwa_pkg::AccW'(in_data.rs);
    nxt  = in_data;
    if (take) begin
      nxt.d    = in_data.d | rrwa_pkg::RingW'(1 << K);
      nxt.dsqs = cand;
      nxt.ds   = in_data.ds + (rrwa_pkg::DsW'(s_cfg) << K);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rrwa_offset.sv -----
// Phase, sine/cosine lookup and gain stages: ring index to signed x and y offsets.
`default_nettype none
module rrwa_offset (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [rrwa_pkg::StepW-1:0]    phase_step,
  input  wire logic signed [rrwa_pkg::AmpW-1:0] x_amplitude,
  input  wire logic signed [rrwa_pkg::AmpW-1:0] y_amplitude,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire rrwa_pkg::srch_t               in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output rrwa_pkg::offs_t                    out_data
);

  localparam int PW = rrwa_pkg::RingW + rrwa_pkg::StepW;

  // stage 1: phase
  logic                          v1;
  logic                          ld1;
  logic [rrwa_pkg::PhaseW-1:0]   ph1;
  logic [rrwa_pkg::CoordW-1:0]   px1, py1;
  // stage 2: table lookup
  logic                          v2;
  logic                          ld2;
  logic signed [rrwa_pkg::AmpW-1:0] sn2, cs2;
  logic [rrwa_pkg::CoordW-1:0]   px2, py2;
  // stage 3: gain
  logic                          ld3;

  logic [PW-1:0]                 prod;
  logic [rrwa_pkg::PhaseW-1:0]   cidx;
  logic signed [2*rrwa_pkg::AmpW-1:0] gx, gy;

  assign ld3      = !out_valid || out_ready;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;

  assign prod = PW'(in_data.d) * PW'(phase_step);
  assign cidx = ph1 + rrwa_pkg::PhaseW'(256);
  assign gx   = cs2 * x_amplitude;
  assign gy   = sn2 * y_amplitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) begin
      ph1 <= {prod[12:4], 1'b0};
      px1 <= in_data.px;
      py1 <= in_data.py;
    end
    if (ld2 && v1) begin
      sn2 <= rrwa_pkg::sine_read(ph1);
      cs2 <= rrwa_pkg::sine_read(cidx);
      px2 <= px1;
      py2 <= py1;
    end
    if (ld3 && v2) begin
      out_data.px   <= px2;
      out_data.py   <= py2;
      out_data.offx <= rrwa_pkg::OffW'(gx >>> 15);
      out_data.offy <= rrwa_pkg::OffW'(gy >>> 15);
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for the radial ripple warp address generator: table-driven and random pixels.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  radial_ripple_warp_address dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the configuration registers
  logic [10:0]        img_w, img_h;
  logic signed [15:0] amp_x, amp_y;
  logic [12:0]        step;

  int quarter_sine [0:256];
  logic [19:0] expected_src [$];
  int mismatches = 0;
  int send_idle = 0, recv_stall = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  // sine table built from $sin, truncated as the block does
  initial begin
    for (int j = 0; j <= 256; j++) quarter_sine[j] = $rtoi($sin(j * 3.14159265358979323846 / 512.0) * 32767.0);
    quarter_sine[0] = 0;
    quarter_sine[256] = 32767;
  end

  function automatic longint sine_of(int unsigned j);
    int unsigned k;
    longint v;
    k = j & 511;
    v = quarter_sine[(k <= 256) ? k : 512 - k];
    return (j & 512) ? -v : v;
  endfunction

  function automatic longint floor_q15(longint v);
    return v >>> 15;
  endfunction

  function automatic int clamp_to_size(longint v, int unsigned size);
    longint maxv;
    if (size == 0) maxv = 0;
    else if (size > 1024) maxv = 1023;
    else maxv = size - 1;
    if (v < 0) return 0;
    if (v > maxv) return int'(maxv);
    return int'(v);
  endfunction

  function automatic logic [19:0] warp_source(logic [9:0] px, logic [9:0] py);
    longint hw, hh, cx, cy, s, r, d, c, offx, offy;
    int unsigned p;
    hw = img_w >> 1;
    hh = img_h >> 1;
    cx = longint'(px) - hw;
    cy = longint'(py) - hh;
    s = hw * hw + hh * hh;
    r = (cx * cx + cy * cy) * 262144;
    d = 0;
    for (int b = 256; b != 0; b >>= 1) begin
      c = d | b;
      if (c < 512 && c * c * s <= r) d = c;
    end
    p = int'(((d * step) >> 3) & 'h3FE);
    offy = floor_q15(sine_of(p) * amp_y);
    offx = floor_q15(sine_of((p + 256) % 1024) * amp_x);
    return {10'(clamp_to_size(longint'(py) + offy, img_h)),
            10'(clamp_to_size(longint'(px) + offx, img_w))};
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      rrwa_pkg::RegWidth:  img_w = val[10:0];
      rrwa_pkg::RegHeight: img_h = val[10:0];
      rrwa_pkg::RegXAmp:   amp_x = val[15:0];
      rrwa_pkg::RegYAmp:   amp_y = val[15:0];
      rrwa_pkg::RegStep:   step  = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int w, int h, int ax, int ay, int st);
    write_reg(rrwa_pkg::RegWidth, w);
    write_reg(rrwa_pkg::RegHeight, h);
    write_reg(rrwa_pkg::RegXAmp, ax);
    write_reg(rrwa_pkg::RegYAmp, ay);
    write_reg(rrwa_pkg::RegStep, st);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_src.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // One beat; golden is checked against the predictor only when non-negative.
  // tvalid stays up after the beat so that the next one follows without a gap.
  task automatic send_pixel(logic [9:0] px, logic [9:0] py, int golden);
    logic [19:0] exp_v;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    exp_v = warp_source(px, py);
    if (golden >= 0 && exp_v != golden[19:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row mismatch px=%0d py=%0d want %h model %h", px, py, golden, exp_v);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, py, px};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_src.push_back(exp_v);
    @(negedge clk);
  endtask

  // Receiver and checker
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_src.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        logic [19:0] e;
        e = expected_src.pop_front();
        if (m_axis_tdata[9:0] != e[9:0] || m_axis_tdata[19:10] != e[19:10]
            || m_axis_tdata[23:20] != 4'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: source_x exp %0d got %0d, source_y exp %0d got %0d",
                     e[9:0], m_axis_tdata[9:0], e[19:10], m_axis_tdata[19:10]);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel
        || hold_cycles > 0)
      quiet_cycles <= 0;
    else if (s_axis_tvalid || expected_src.size() != 0)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  typedef struct {
    logic [9:0] px;
    logic [9:0] py;
    int golden;
  } pixel_row_t;

  pixel_row_t dir_rows [$];

  task automatic random_phase(int n, int idle, int stall);
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < n; i++) begin
      logic [9:0] px, py;
      if ($urandom_range(3) == 0) begin
        px = 10'($urandom); py = 10'($urandom);
      end else begin
        px = 10'($urandom_range((img_w > 1024) ? 1023 : ((img_w == 0) ? 0 : img_w - 1)));
        py = 10'($urandom_range((img_h > 1024) ? 1023 : ((img_h == 0) ? 0 : img_h - 1)));
      end
      send_pixel(px, py, -1);
    end
  endtask

  task automatic random_config();
    int w, h;
    w = ($urandom_range(3) == 0) ? $urandom_range(2047) : 2 * $urandom_range(1, 512);
    h = ($urandom_range(3) == 0) ? $urandom_range(2047) : 2 * $urandom_range(1, 512);
    set_config(w, h, $urandom, $urandom, $urandom);
  endtask

  initial begin
    img_w = 320; img_h = 240; amp_x = 0; amp_y = 0; step = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset config: zero gains leave the pixel as is
    dir_rows.push_back('{10'd0, 10'd0, 0});
    dir_rows.push_back('{10'd319, 10'd239, {10'd239, 10'd319}});
    dir_rows.push_back('{10'd160, 10'd120, {10'd120, 10'd160}});
    // outside the image clamps to the max
    dir_rows.push_back('{10'd1023, 10'd1023, {10'd239, 10'd319}});
    dir_rows.push_back('{10'd1023, 10'd0, {10'd0, 10'd319}});
    foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].py, dir_rows[i].golden);
    drain();

    // Extremes: full gains, odd sizes, zero size, size over the limit
    set_config(1024, 1024, 32767, -32768, 8191);
    for (int i = 0; i < 6; i++) send_pixel(10'(i * 200), 10'(1023 - i * 200), -1);
    send_pixel(10'd512, 10'd512, -1);
    drain();
    set_config(0, 0, -32768, 32767, 1);
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd5, 10'd700, 0);
    drain();
    set_config(2047, 1025, 32767, 32767, 4096);
    send_pixel(10'd1023, 10'd1023, -1);
    send_pixel(10'd0, 10'd0, -1);
    send_pixel(10'd511, 10'd512, -1);
    drain();
    set_config(7, 3, 12345, -777, 8);
    send_pixel(10'd3, 10'd1, -1);
    send_pixel(10'd6, 10'd2, -1);
    send_pixel(10'd0, 10'd0, -1);
    drain();

    set_config(320, 240, 3000, -2500, 100);
    random_phase(250, 0, 0);
    drain();
    random_config();
    random_phase(250, 55, 0);
    drain();
    random_config();
    random_phase(250, 0, 55);
    drain();
    random_config();
    random_phase(250, 10, 10);
    // receiver holds off long while pixels keep coming
    hold_cycles = 200;
    random_phase(60, 0, 0);
    drain();
    // sender pauses until everything has come back
    random_config();
    random_phase(150, 0, 0);
    drain();

    if (mismatches == 0 && expected_src.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- radial_ripple_warp_address.f -----
rtl/rrwa_pkg.sv
rtl/rrwa_search.sv
rtl/rrwa_offset.sv
rtl/radial_ripple_warp_address.sv
bench/tb_top.sv
